@@ rtl/core/base64_stream_encoder_assert.svh @@
// assertion macros shared by the checker of the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define B64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define B64_NEVER(label, cond, msg) \
  `B64_ASSERT(label, !(cond), msg)

`endif

@@ rtl/core/b64enc_pkg.sv @@
// shared types, constants and the alphabet function of the base64 encoder
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

  // default characters per line before a break
  localparam int unsigned LINE_CHARS_DEF = 76;
  // default depth of the group command queue
  localparam int unsigned CMD_DEPTH_DEF  = 2;
  // configuration address width and register index
  localparam int unsigned ADDR_W         = 3;
  localparam logic        REG_LINE_BREAK = 1'b0;

  // special characters
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // padding amount of a group
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_e;

  // one encoded group as handed from front to back
  typedef struct packed {
    logic [3:0][5:0] sext;
    pad_e            pad;
    logic            last;
    logic            crlf;
  } grp_cmd_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64enc_front.sv @@
// front end: gathers bytes into groups and issues one command per group
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front import b64enc_pkg::*; #(
  parameter int unsigned LineChars = LINE_CHARS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic     final_byte_i,
  input  wire logic     line_break_en_i,
  output logic          cmd_valid_o,
  output grp_cmd_t      cmd_o
);

  localparam int unsigned CntW = $clog2(LineChars + 4);

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      b0_q, b0_d, b1_q, b1_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_sum;

  assign cnt_sum = cnt_q + CntW'(4);

  // group assembly and line counting
  always_comb begin
    phase_d     = phase_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    cnt_d       = cnt_q;
    cmd_valid_o = 1'b0;
    cmd_o.sext  = '0;
    cmd_o.pad   = PAD_NONE;
    cmd_o.last  = final_byte_i;
    cmd_o.crlf  = 1'b0;
    case (phase_q)
      2'd1: begin
        cmd_o.sext[0] = b0_q[7:2];
        cmd_o.sext[1] = {b0_q[1:0], data_byte_i[7:4]};
        cmd_o.sext[2] = {data_byte_i[3:0], 2'b00};
        cmd_o.pad     = PAD_ONE;
        if (accept_i) begin
          if (final_byte_i) begin
            cmd_valid_o = 1'b1;
            phase_d     = 2'd0;
            cnt_d       = '0;
          end else begin
            b1_d    = data_byte_i;
            phase_d = 2'd2;
          end
        end
      end
      2'd2: begin
        cmd_o.sext[0] = b0_q[7:2];
        cmd_o.sext[1] = {b0_q[1:0], b1_q[7:4]};
        cmd_o.sext[2] = {b1_q[3:0], data_byte_i[7:6]};
        cmd_o.sext[3] = data_byte_i[5:0];
        if (!final_byte_i && cnt_sum >= CntW'(LineChars)) begin
          cmd_o.crlf = line_break_en_i;
        end
        if (accept_i) begin
          cmd_valid_o = 1'b1;
          phase_d     = 2'd0;
          if (final_byte_i || cnt_sum >= CntW'(LineChars)) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt_sum;
          end
        end
      end
      default: begin
        cmd_o.sext[0] = data_byte_i[7:2];
        cmd_o.sext[1] = {data_byte_i[1:0], 4'b0000};
        cmd_o.pad     = PAD_TWO;
        if (accept_i) begin
          if (final_byte_i) begin
            cmd_valid_o = 1'b1;
            phase_d     = 2'd0;
            cnt_d       = '0;
          end else begin
            b0_d    = data_byte_i;
            phase_d = 2'd1;
          end
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // held bytes
  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/b64enc_cmd_fifo.sv @@
// short queue of group commands between front and back
`timescale 1ns / 1ps
`default_nettype none

module b64enc_cmd_fifo import b64enc_pkg::*; #(
  parameter int unsigned Depth = CMD_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire grp_cmd_t wr_data_i,
  output logic          full_o,
  input  wire logic     rd_i,
  output logic          empty_o,
  output grp_cmd_t      rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64enc_back.sv @@
// back end: expands one group command into characters, one per cycle while the receiver keeps popping
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back import b64enc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_empty_i,
  input  wire grp_cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  wire logic     pop_i,
  output logic [7:0]    out_char_o,
  output logic          out_last_o
);

  grp_cmd_t   cur_q;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       advance, at_end, load;
  logic [7:0] next_char;
  logic       next_last;

  assign advance = busy_q && (!out_valid_q || pop_i);
  assign at_end  = cur_q.crlf ? (idx_q == 3'd5) : (idx_q == 3'd3);
  assign load    = !busy_q || (advance && at_end);
  assign cmd_pop_o = load && !cmd_empty_i;

  // character for the current position
  always_comb begin
    next_last = 1'b0;
    case (idx_q)
      3'd0: next_char = b64_char(cur_q.sext[0]);
      3'd1: next_char = b64_char(cur_q.sext[1]);
      3'd2: next_char = (cur_q.pad == PAD_TWO) ? CHAR_PAD : b64_char(cur_q.sext[2]);
      3'd3: begin
        next_char = (cur_q.pad == PAD_NONE) ? b64_char(cur_q.sext[3]) : CHAR_PAD;
        next_last = cur_q.last;
      end
      3'd4: next_char = CHAR_CR;
      3'd5: next_char = CHAR_LF;
      default: next_char = CHAR_PAD;
    endcase
  end

  // sequencing over the characters of a group
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 3'd1;
    end
    if (load) begin
      busy_d = !cmd_empty_i;
      idx_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (advance) begin
      char_q <= next_char;
      last_q <= next_last;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_char_o = char_q;
  assign out_last_o = last_q;

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_encoder.sv @@
// Base64 stream encoder: raw bytes in, standard-alphabet characters out,
// with optional CR LF after every LineChars characters (MIME style, not
// after the final group). The front end takes one byte per cycle while the
// group command queue has room; each third byte, or the final byte, issues a
// group command. The back end sends one character per cycle from its output
// register while the receiver pops, four characters per group or six with a
// line break, so the single character output sets the sustained byte rate.
// A group's first character passes the command queue, the back end's group
// register and its output register on its way out. Register 0 at
// byte address 0, bit 0: line break enable, reset 0; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int unsigned LineChars = LINE_CHARS_DEF,
  parameter int unsigned CmdDepth  = CMD_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              final_byte_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_char_o,
  output logic                   out_last_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic     line_break_en_q;
  logic     accept;
  logic     cmd_valid, cmd_full, cmd_empty, cmd_pop;
  grp_cmd_t cmd_in, cmd_out;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_BREAK) ? {31'd0, line_break_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_break_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_BREAK) begin
      line_break_en_q <= pwdata[0];
    end
  end

  // input request handshake
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  b64enc_front #(
    .LineChars (LineChars)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .final_byte_i    (final_byte_i),
    .line_break_en_i (line_break_en_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd_in)
  );

  b64enc_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd_in),
    .full_o    (cmd_full),
    .rd_i      (cmd_pop),
    .empty_o   (cmd_empty),
    .rd_data_o (cmd_out)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/b64enc_checker.sv @@
// port level checks of the base64 stream encoder and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_encoder_assert.svh"

module b64enc_checker import b64enc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [7:0]        out_char_o,
  input wire logic              out_last_o,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [31:0]       pwdata,
  input wire logic [31:0]       prdata,
  input wire logic              pready
);

  // a waiting result holds until taken
  `B64_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(out_char_o) && $stable(out_last_o), "result changed while stalled")

  // a line break is never split: LF follows a taken CR at once
  `B64_ASSERT(a_crlf_pair, !empty && pop && out_char_o == CHAR_CR |=> !empty && out_char_o == CHAR_LF, "CR not followed by LF")

  // the final character of an encoding is never part of a line break
  `B64_NEVER(a_last_not_break, !empty && out_last_o && (out_char_o == CHAR_CR || out_char_o == CHAR_LF), "last flag on a line break")

  // register 0 reads back what was written
  `B64_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && paddr == '0 |=> !psel || pwrite || paddr != '0 || prdata[0] == $past(pwdata[0]), "line break enable readback mismatch")

endmodule

bind base64_stream_encoder b64enc_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the base64 stream encoder
`timescale 1ns / 1ps

module tb_top;
  import b64enc_pkg::*;

  localparam int unsigned LINE_LEN     = LINE_CHARS_DEF;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [ADDR_W-1:0] LBE_ADDR       = ADDR_W'(4 * int'(REG_LINE_BREAK));
  localparam logic [ADDR_W-1:0] SPARE_REG_ADDR = ADDR_W'(4 * (int'(REG_LINE_BREAK) + 1));
  // standard alphabet, index 0 in the top byte
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // dut ports
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              push         = 1'b0;
  logic              full;
  logic [7:0]        data_byte_i  = 8'h00;
  logic              final_byte_i = 1'b0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [7:0]        out_char_o;
  logic              out_last_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  // encoder state mirrored by the testbench
  logic        crlf_on;
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [6:0]  line_fill;
  enc_char_t   encoded_chars_q[$];

  // run bookkeeping
  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned bytes_sent   = 0;
  int unsigned msgs_sent    = 0;
  int unsigned chars_seen   = 0;
  int unsigned breaks_made  = 0;
  int unsigned full_waits   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned burst_left   = 0;
  bit          sender_gaps  = 1'b1;
  bit          hold_req     = 1'b0;

  base64_stream_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .out_last_o   (out_last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still owed",
               cycle_cnt, encoded_chars_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic last);
    enc_char_t c;
    c.ch   = ch;
    c.last = last;
    encoded_chars_q.push_back(c);
  endfunction

  function automatic void clear_message();
    held_bytes = '0;
    held_count = '0;
    line_fill  = '0;
  endfunction

  // expected characters for one accepted byte
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    int unsigned fill;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    // a count of three is never reached and acts like an empty group
    if (held_count == 2'd0 || held_count == 2'd3) begin
      if (!fin) begin
        held_bytes = {b, 8'h00};
        held_count = 2'd1;
      end else begin
        emit(sextet_char(b[7:2]), 1'b0);
        emit(sextet_char({b[1:0], 4'b0000}), 1'b0);
        emit(CHAR_PAD, 1'b0);
        emit(CHAR_PAD, 1'b1);
        clear_message();
      end
    end else if (held_count == 2'd1) begin
      if (!fin) begin
        held_bytes = {b0, b};
        held_count = 2'd2;
      end else begin
        emit(sextet_char(b0[7:2]), 1'b0);
        emit(sextet_char({b0[1:0], b[7:4]}), 1'b0);
        emit(sextet_char({b[3:0], 2'b00}), 1'b0);
        emit(CHAR_PAD, 1'b1);
        clear_message();
      end
    end else begin
      // full group of three
      emit(sextet_char(b0[7:2]), 1'b0);
      emit(sextet_char({b0[1:0], b1[7:4]}), 1'b0);
      emit(sextet_char({b1[3:0], b[7:6]}), 1'b0);
      emit(sextet_char(b[5:0]), fin);
      if (fin) begin
        clear_message();
      end else begin
        held_bytes = '0;
        held_count = '0;
        fill = int'(line_fill) + 4;
        // line count wraps even with breaks off
        if (fill >= LINE_LEN) begin
          fill = 0;
          if (crlf_on) begin
            emit(CHAR_CR, 1'b0);
            emit(CHAR_LF, 1'b0);
            breaks_made++;
          end
        end
        line_fill = fill[6:0];
      end
    end
  endfunction

  // offer one byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    @(negedge clk_i);
    push         <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (full) begin
      full_waits++;
      @(posedge clk_i);
    end
    encode_byte(b, fin);
    bytes_sent++;
    // bursts with random gaps in between
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (encoded_chars_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random message; the sender stops at pause_at until all output is out
  task automatic send_message(input int unsigned len, input int pause_at);
    for (int i = 0; i < int'(len); i++) begin
      if (i == pause_at) begin
        sender_idle();
        while (encoded_chars_q.size() != 0) @(posedge clk_i);
      end
      send_byte(8'($urandom), i == int'(len) - 1);
    end
    sender_idle();
    msgs_sent++;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  // write the line break enable while idle and read it back
  task automatic set_line_break(input logic v);
    logic [31:0] rd;
    wait_drained();
    apb_write(LBE_ADDR, {31'($urandom), v});
    crlf_on = v;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LBE_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== v) begin
      $error("prdata: expected %0b, actual %0b", v, rd[0]);
      err_cnt++;
    end
  endtask

  // receiver: stall patterns, long hold on request, and result check
  initial begin : rx_proc
    enc_char_t   want;
    int unsigned pat_cnt;
    int unsigned stall_mode;
    int unsigned hold_left;
    pat_cnt    = 0;
    stall_mode = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      pat_cnt++;
      if (pat_cnt == 48) begin
        pat_cnt    = 0;
        stall_mode = $urandom_range(0, 3);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (stall_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (pat_cnt % 3 == 0);
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        chars_seen++;
        if (encoded_chars_q.size() == 0) begin
          $error("out_char: no character expected, actual %h", out_char_o);
          err_cnt++;
        end else begin
          want = encoded_chars_q.pop_front();
          if (out_char_o !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char_o);
            err_cnt++;
          end
          if (out_last_o !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // short messages, all-zero and all-one bytes, '+' and '/' at reset setting
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    sender_idle();
    msgs_sent += 9;
  endtask

  // line boundary: final full group, break then one or two leftover bytes
  task automatic test_line_breaks();
    set_line_break(1'b1);
    send_message(57, -1);
    send_message(58, -1);
    send_message(59, -1);
  endtask

  // random messages under both settings, spare register written too
  task automatic test_random_messages();
    int unsigned start;
    int unsigned len;
    set_line_break(1'b0);
    apb_write(SPARE_REG_ADDR, 32'($urandom) | 32'h1);
    for (int blk = 0; blk < 4; blk++) begin
      set_line_break(blk[0]);
      sender_gaps = (blk != 2);
      start = bytes_sent;
      while (bytes_sent - start < 14) begin
        if ($urandom_range(0, 9) < 8) len = $urandom_range(1, 12);
        else                          len = $urandom_range(40, 80);
        send_message(len, -1);
      end
    end
    sender_gaps = 1'b1;
  endtask

  // long receiver hold while the sender keeps pushing
  task automatic test_backpressure();
    set_line_break(1'b1);
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    send_message(40, -1);
    sender_gaps = 1'b1;
  endtask

  // sender waits mid-message for all output, with two and with zero held
  task automatic test_sender_pause();
    set_line_break(1'b0);
    send_message(16, 14);
    send_message(16, 9);
  endtask

  initial begin
    crlf_on = 1'b0;
    clear_message();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_messages();
    test_line_breaks();
    test_random_messages();
    test_backpressure();
    test_sender_pause();

    wait_drained();
    $display("encoded %0d messages of %0d bytes, %0d characters checked, %0d line breaks",
             msgs_sent, bytes_sent, chars_seen, breaks_made);
    $display("%0d register writes, %0d cycles with input held off by full",
             cfg_writes, full_waits);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
